FILE: rtl/obb_pkg.sv
// ---------------------------------------------------------------------------
// Oriented box overlap package
// Shared widths, the queue entry type and the sine table.
// ---------------------------------------------------------------------------
package obb_pkg;

	localparam int COORD_BITS     = 16;
	localparam int TRIG_FRAC_BITS = 15;
	localparam int LEN_W          = 12;
	localparam int ANG_W          = 9;
	localparam int IN_BITS        = 4 * COORD_BITS + 4 * LEN_W + 2 * ANG_W;
	localparam int IN_DATA_W      = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W     = 8;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int TRIG_W = TRIG_FRAC_BITS + 2;
	localparam int PROD_W = (DIFF_W > TRIG_W ? DIFF_W : TRIG_W) + TRIG_W;
	localparam int NORM_W = 2 * TRIG_FRAC_BITS + 2;
	localparam int PROJ_W = DIFF_W + TRIG_FRAC_BITS + 1;
	localparam int TERM_W = LEN_W + NORM_W;
	localparam int SUM_W  = TERM_W + 2;
	localparam int CMP_W  = PROJ_W + TRIG_FRAC_BITS + 1;

	localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(90);
	localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(180);
	localparam logic [ANG_W-1:0] DEG_270 = ANG_W'(270);
	localparam logic [ANG_W:0]   DEG_360 = (ANG_W + 1)'(360);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam longint unsigned DEG_TO_RAD_Q30 = 64'd18740330;
	localparam longint unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic [90:0][TRIG_FRAC_BITS:0] sin_tab_t;

	// One classified pair as it waits between the front and the back.
	typedef struct packed {
		diff_t            dx;
		diff_t            dy;
		logic [LEN_W-1:0] w1;
		logic [LEN_W-1:0] h1;
		logic [LEN_W-1:0] w2;
		logic [LEN_W-1:0] h2;
		logic [ANG_W-1:0] a1;
		logic [ANG_W-1:0] a2;
		logic             aligned;
	} pair_t;

	// Quarter-wave sine, Taylor series in Q30, evaluated at elaboration.
	function automatic sin_tab_t build_sin_tab();
		sin_tab_t          tab;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint            sum;
		longint unsigned   rnd;
		for (int a = 0; a <= 90; a++) begin
			x    = longint'(a) * DEG_TO_RAD_Q30;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int k = 1; k <= 6; k++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
				if (k % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			rnd    = (longint'(sum) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
			tab[a] = rnd[TRIG_FRAC_BITS:0];
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

	// Sine of a reduced angle (0 to 359 degrees) by quadrant symmetry.
	function automatic trig_t sine_deg(input logic [ANG_W-1:0] a);
		logic [6:0] idx;
		logic       neg;
		logic [TRIG_FRAC_BITS:0] mag;
		if (a <= DEG_90) begin
			idx = a[6:0];
			neg = 1'b0;
		end else if (a <= DEG_180) begin
			idx = 7'(DEG_180 - a);
			neg = 1'b0;
		end else if (a <= DEG_270) begin
			idx = 7'(a - DEG_180);
			neg = 1'b1;
		end else begin
			idx = 7'(DEG_360 - {1'b0, a});
			neg = 1'b1;
		end
		mag = SIN_TAB[idx];
		return neg ? -trig_t'({1'b0, mag}) : trig_t'({1'b0, mag});
	endfunction

	// Cosine as the sine of the angle plus 90 degrees.
	function automatic trig_t cosine_deg(input logic [ANG_W-1:0] a);
		logic [ANG_W:0] b;
		b = {1'b0, a} + {1'b0, DEG_90};
		if (b >= DEG_360) begin
			b = b - DEG_360;
		end
		return sine_deg(b[ANG_W-1:0]);
	endfunction

endpackage

FILE: rtl/obb_front.sv
// ---------------------------------------------------------------------------
// Oriented box overlap front end
// Takes input words, reduces angles, forms the center difference and
// decides between the axis-aligned and the rotated test.
// ---------------------------------------------------------------------------
module obb_front import obb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	output logic                 pair_valid,
	input  logic                 pair_ready,
	output pair_t                pair
);

	logic  valid_q;
	pair_t pair_q;
	pair_t pair_d;

	logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
	logic [ANG_W-1:0]             ra1, ra2, a1_raw, a2_raw;

	// Field unpacking, first field in the lowest bits.
	always_comb begin
		x1     = s_tdata[COORD_BITS-1:0];
		y1     = s_tdata[2*COORD_BITS-1 -: COORD_BITS];
		a1_raw = s_tdata[2*COORD_BITS+2*LEN_W +: ANG_W];
		x2     = s_tdata[2*COORD_BITS+2*LEN_W+ANG_W +: COORD_BITS];
		y2     = s_tdata[3*COORD_BITS+2*LEN_W+ANG_W +: COORD_BITS];
		a2_raw = s_tdata[4*COORD_BITS+4*LEN_W+ANG_W +: ANG_W];
		ra1    = ({1'b0, a1_raw} >= DEG_360) ? ANG_W'({1'b0, a1_raw} - DEG_360) : a1_raw;
		ra2    = ({1'b0, a2_raw} >= DEG_360) ? ANG_W'({1'b0, a2_raw} - DEG_360) : a2_raw;
		pair_d.dx = diff_t'(x1) - diff_t'(x2);
		pair_d.dy = diff_t'(y1) - diff_t'(y2);
		pair_d.w1 = s_tdata[2*COORD_BITS +: LEN_W];
		pair_d.h1 = s_tdata[2*COORD_BITS+LEN_W +: LEN_W];
		pair_d.w2 = s_tdata[4*COORD_BITS+2*LEN_W+ANG_W +: LEN_W];
		pair_d.h2 = s_tdata[4*COORD_BITS+3*LEN_W+ANG_W +: LEN_W];
		pair_d.a1 = ra1;
		pair_d.a2 = ra2;
		pair_d.aligned = ((ra1 == DEG_90) || (ra1 == DEG_270)) && (ra2 == DEG_90);
	end

	assign s_tready   = !valid_q || pair_ready;
	assign pair_valid = valid_q;
	assign pair       = pair_q;

	// Valid flag of the front register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	// Classified word.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pair_q <= pair_d;
		end
	end

endmodule

FILE: rtl/obb_fifo.sv
// ---------------------------------------------------------------------------
// Oriented box overlap queue
// Short queue that lets the front end and the back end stall apart.
// ---------------------------------------------------------------------------
module obb_fifo import obb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  pair_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output pair_t pop_data
);

	pair_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full      = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/obb_back.sv
// ---------------------------------------------------------------------------
// Oriented box overlap back end
// Five-stage pipeline: trig lookup, products, dot products, scaled extents,
// then the separating-axis compare and the output register.
// ---------------------------------------------------------------------------
module obb_back import obb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pair_valid,
	output logic                  pair_pop,
	input  pair_t                 pair,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Stage 1 registers.
	diff_t            dx_s1, dy_s1;
	trig_t            s1_s1, c1_s1, s2_s1, c2_s1;
	logic [LEN_W-1:0] w1_s1, h1_s1, w2_s1, h2_s1;
	logic             aligned_s1, aa_hit_s1, zero_s1;

	// Stage 2 registers.
	logic signed [PROD_W-1:0] cc1_s2, ss1_s2, cc2_s2, ss2_s2;
	logic signed [PROD_W-1:0] c1c2_s2, s1s2_s2, c1s2_s2, s1c2_s2;
	logic signed [PROD_W-1:0] dxc1_s2, dys1_s2, dxs1_s2, dyc1_s2;
	logic signed [PROD_W-1:0] dxc2_s2, dys2_s2, dxs2_s2, dyc2_s2;
	logic [LEN_W-1:0]         w1_s2, h1_s2, w2_s2, h2_s2;
	logic                     aligned_s2, aa_hit_s2, zero_s2;

	// Stage 3 registers.
	logic [NORM_W-1:0] n1_s3, n2_s3, p_s3, q_s3;
	logic [PROJ_W-1:0] proj_s3 [4];
	logic [LEN_W-1:0]  w1_s3, h1_s3, w2_s3, h2_s3;
	logic              aligned_s3, aa_hit_s3, zero_s3;

	// Stage 4 registers.
	logic [TERM_W-1:0] h1n1_s4, w1n1_s4, h2n2_s4, w2n2_s4;
	logic [TERM_W-1:0] h1p_s4, h1q_s4, w1p_s4, w1q_s4;
	logic [TERM_W-1:0] h2p_s4, h2q_s4, w2p_s4, w2q_s4;
	logic [PROJ_W-1:0] proj_s4 [4];
	logic              aligned_s4, aa_hit_s4, zero_s4;

	logic overlap_s5;

	logic signed [DIFF_W+1:0] dx2, dy2, sx, sy;
	logic signed [PROD_W:0]   sum_p, sum_q, sum_n1, sum_n2;
	logic signed [PROD_W:0]   sum_proj [4];
	logic [SUM_W-1:0]         need [4];
	logic [3:0]               sep;

	// The whole pipeline moves unless a finished word waits at the output.
	assign en       = !v_s5 || m_tready;
	assign pair_pop = en && pair_valid;
	assign m_tvalid = v_s5;
	assign m_tdata  = {(OUT_DATA_W - 1)'(0), overlap_s5};

	// Valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Axis-aligned comparison operands, doubled center distance.
	always_comb begin
		dx2 = (DIFF_W + 2)'(pair.dx) <<< 1;
		dy2 = (DIFF_W + 2)'(pair.dy) <<< 1;
		sx  = (DIFF_W + 2)'({1'b0, pair.w1}) + (DIFF_W + 2)'({1'b0, pair.w2});
		sy  = (DIFF_W + 2)'({1'b0, pair.h1}) + (DIFF_W + 2)'({1'b0, pair.h2});
	end

	// Stage 1: trig lookup and the aligned test.
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1      <= pair.dx;
			dy_s1      <= pair.dy;
			s1_s1      <= sine_deg(pair.a1);
			c1_s1      <= cosine_deg(pair.a1);
			s2_s1      <= sine_deg(pair.a2);
			c2_s1      <= cosine_deg(pair.a2);
			w1_s1      <= pair.w1;
			h1_s1      <= pair.h1;
			w2_s1      <= pair.w2;
			h2_s1      <= pair.h2;
			aligned_s1 <= pair.aligned;
			aa_hit_s1  <= (dx2 < sx) && (dx2 > -sx) && (dy2 < sy) && (dy2 > -sy);
			zero_s1    <= (pair.w1 == '0) || (pair.h1 == '0) ||
			              (pair.w2 == '0) || (pair.h2 == '0);
		end
	end

	// Stage 2: all products of trig values and of the center difference.
	always_ff @(posedge clk) begin
		if (en) begin
			cc1_s2     <= PROD_W'(c1_s1) * PROD_W'(c1_s1);
			ss1_s2     <= PROD_W'(s1_s1) * PROD_W'(s1_s1);
			cc2_s2     <= PROD_W'(c2_s1) * PROD_W'(c2_s1);
			ss2_s2     <= PROD_W'(s2_s1) * PROD_W'(s2_s1);
			c1c2_s2    <= PROD_W'(c1_s1) * PROD_W'(c2_s1);
			s1s2_s2    <= PROD_W'(s1_s1) * PROD_W'(s2_s1);
			c1s2_s2    <= PROD_W'(c1_s1) * PROD_W'(s2_s1);
			s1c2_s2    <= PROD_W'(s1_s1) * PROD_W'(c2_s1);
			dxc1_s2    <= PROD_W'(dx_s1) * PROD_W'(c1_s1);
			dys1_s2    <= PROD_W'(dy_s1) * PROD_W'(s1_s1);
			dxs1_s2    <= PROD_W'(dx_s1) * PROD_W'(s1_s1);
			dyc1_s2    <= PROD_W'(dy_s1) * PROD_W'(c1_s1);
			dxc2_s2    <= PROD_W'(dx_s1) * PROD_W'(c2_s1);
			dys2_s2    <= PROD_W'(dy_s1) * PROD_W'(s2_s1);
			dxs2_s2    <= PROD_W'(dx_s1) * PROD_W'(s2_s1);
			dyc2_s2    <= PROD_W'(dy_s1) * PROD_W'(c2_s1);
			w1_s2      <= w1_s1;
			h1_s2      <= h1_s1;
			w2_s2      <= w2_s1;
			h2_s2      <= h2_s1;
			aligned_s2 <= aligned_s1;
			aa_hit_s2  <= aa_hit_s1;
			zero_s2    <= zero_s1;
		end
	end

	// Dot products between axes and projections of the center difference.
	// The two axes of one box are perpendicular, so only four dot products
	// remain: the squared lengths and the two cross terms.
	always_comb begin
		sum_n1      = (PROD_W + 1)'(cc1_s2) + (PROD_W + 1)'(ss1_s2);
		sum_n2      = (PROD_W + 1)'(cc2_s2) + (PROD_W + 1)'(ss2_s2);
		sum_p       = (PROD_W + 1)'(c1c2_s2) + (PROD_W + 1)'(s1s2_s2);
		sum_q       = (PROD_W + 1)'(c1s2_s2) - (PROD_W + 1)'(s1c2_s2);
		sum_proj[0] = (PROD_W + 1)'(dxc1_s2) + (PROD_W + 1)'(dys1_s2);
		sum_proj[1] = (PROD_W + 1)'(dxs1_s2) - (PROD_W + 1)'(dyc1_s2);
		sum_proj[2] = (PROD_W + 1)'(dxc2_s2) + (PROD_W + 1)'(dys2_s2);
		sum_proj[3] = (PROD_W + 1)'(dxs2_s2) - (PROD_W + 1)'(dyc2_s2);
	end

	// Stage 3: magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			n1_s3 <= NORM_W'(sum_n1);
			n2_s3 <= NORM_W'(sum_n2);
			p_s3  <= NORM_W'(sum_p[PROD_W] ? -sum_p : sum_p);
			q_s3  <= NORM_W'(sum_q[PROD_W] ? -sum_q : sum_q);
			for (int i = 0; i < 4; i++) begin
				proj_s3[i] <= PROJ_W'(sum_proj[i][PROD_W] ? -sum_proj[i] : sum_proj[i]);
			end
			w1_s3      <= w1_s2;
			h1_s3      <= h1_s2;
			w2_s3      <= w2_s2;
			h2_s3      <= h2_s2;
			aligned_s3 <= aligned_s2;
			aa_hit_s3  <= aa_hit_s2;
			zero_s3    <= zero_s2;
		end
	end

	// Stage 4: extents scaled by the dot products.
	always_ff @(posedge clk) begin
		if (en) begin
			h1n1_s4    <= TERM_W'(h1_s3) * TERM_W'(n1_s3);
			w1n1_s4    <= TERM_W'(w1_s3) * TERM_W'(n1_s3);
			h2n2_s4    <= TERM_W'(h2_s3) * TERM_W'(n2_s3);
			w2n2_s4    <= TERM_W'(w2_s3) * TERM_W'(n2_s3);
			h1p_s4     <= TERM_W'(h1_s3) * TERM_W'(p_s3);
			h1q_s4     <= TERM_W'(h1_s3) * TERM_W'(q_s3);
			w1p_s4     <= TERM_W'(w1_s3) * TERM_W'(p_s3);
			w1q_s4     <= TERM_W'(w1_s3) * TERM_W'(q_s3);
			h2p_s4     <= TERM_W'(h2_s3) * TERM_W'(p_s3);
			h2q_s4     <= TERM_W'(h2_s3) * TERM_W'(q_s3);
			w2p_s4     <= TERM_W'(w2_s3) * TERM_W'(p_s3);
			w2q_s4     <= TERM_W'(w2_s3) * TERM_W'(q_s3);
			proj_s4    <= proj_s3;
			aligned_s4 <= aligned_s3;
			aa_hit_s4  <= aa_hit_s3;
			zero_s4    <= zero_s3;
		end
	end

	// Separated on an axis when the scaled projection reaches the extent sum.
	always_comb begin
		need[0] = SUM_W'(h1n1_s4) + SUM_W'(h2p_s4) + SUM_W'(w2q_s4);
		need[1] = SUM_W'(w1n1_s4) + SUM_W'(h2q_s4) + SUM_W'(w2p_s4);
		need[2] = SUM_W'(h1p_s4) + SUM_W'(w1q_s4) + SUM_W'(h2n2_s4);
		need[3] = SUM_W'(h1q_s4) + SUM_W'(w1p_s4) + SUM_W'(w2n2_s4);
		for (int i = 0; i < 4; i++) begin
			sep[i] = ({proj_s4[i], (TRIG_FRAC_BITS + 1)'(0)} >= CMP_W'(need[i]));
		end
	end

	// Stage 5: output register.
	always_ff @(posedge clk) begin
		if (en) begin
			overlap_s5 <= aligned_s4 ? aa_hit_s4 : (!zero_s4 && (sep == '0));
		end
	end

endmodule

FILE: rtl/oriented_box_overlap_test_top.sv
// ---------------------------------------------------------------------------
// Oriented box overlap test
// Reports whether two rotated rectangles overlap, one word in, one out.
// ---------------------------------------------------------------------------
// The block takes one rectangle pair per clock cycle while s_tready is high
// and returns one overlap bit per pair, in order. Each accepted pair passes
// the front register, the queue and the back-end stages in turn before its
// result word is offered. A front register classifies each pair as the
// axis-aligned special case or the separating-axis test. A four-entry queue
// decouples it from a five-stage back-end pipeline, whose sixteen 17x17 and
// twelve 12x32 multipliers set the depth. Touching rectangles report no
// overlap in the rotated test.
module oriented_box_overlap_test_top import obb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// first_center_x, first_center_y, first_width, first_height, first_angle,
	// second_center_x, second_center_y, second_width, second_height,
	// second_angle, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// overlap, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic  front_valid, fifo_full, fifo_not_empty, fifo_pop;
	pair_t front_pair, fifo_pair;

	obb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.pair_valid (front_valid),
		.pair_ready (!fifo_full),
		.pair       (front_pair)
	);

	obb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid && !fifo_full),
		.push_data (front_pair),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.not_empty (fifo_not_empty),
		.pop_data  (fifo_pair)
	);

	obb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (fifo_not_empty),
		.pair_pop   (fifo_pop),
		.pair       (fifo_pair),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

FILE: rtl/obb_chk.sv
// ---------------------------------------------------------------------------
// Oriented box overlap port checker
// Watches the top-level ports for word-count and handshake slips.
// ---------------------------------------------------------------------------
module obb_chk import obb_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	logic [3:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A result never appears without an accepted pair behind it.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pending_q != '0))
		else $error("result shown with no pair outstanding");

	// Fill bits of the result word stay zero.
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_DATA_W-1:1] == '0))
		else $error("result fill bits set");

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind oriented_box_overlap_test_top obb_chk u_obb_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: bench/obb_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Oriented box overlap checker
// Watches both stream channels and predicts the overlap bit of every
// accepted pair. Each result word is compared in order with the oldest
// prediction, and a count of mismatches goes back to the bench top.
// ---------------------------------------------------------------------------
module obb_checker import obb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    errors,
	output int                    pending
);

	// Predicted overlap bits, oldest first.
	bit      overlap_q[$];
	longint  quarter_sin[0:90];

	// Quarter-wave sine in Q1.15 from a truncated Taylor series in Q30.
	initial begin
		longint unsigned x, x2, term;
		longint          acc;
		for (int a = 0; a <= 90; a++) begin
			x    = longint'(a) * 64'd18740330;
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (int k = 1; k <= 6; k++) begin
				term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
				acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0) begin
				acc = 0;
			end
			quarter_sin[a] = (acc + (longint'(1) << (29 - TRIG_FRAC_BITS)))
				>>> (30 - TRIG_FRAC_BITS);
		end
	end

	function automatic longint sin_deg(int a);
		a = a % 360;
		if (a <= 90) begin
			return quarter_sin[a];
		end else if (a <= 180) begin
			return quarter_sin[180 - a];
		end else if (a <= 270) begin
			return -quarter_sin[a - 180];
		end
		return -quarter_sin[360 - a];
	endfunction

	function automatic longint abs_of(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Overlap of the pair carried by one input word.
	function automatic bit predict_overlap(logic [IN_DATA_W-1:0] d);
		longint x1, y1, x2, y2, dx, dy, sx, sy, proj, sum, need;
		longint w1, h1, w2, h2;
		int     a1, a2;
		longint ux[4], uy[4], len[4];
		x1 = longint'($signed(d[15:0]));
		y1 = longint'($signed(d[31:16]));
		w1 = d[43:32];
		h1 = d[55:44];
		a1 = int'(d[64:56]) % 360;
		x2 = longint'($signed(d[80:65]));
		y2 = longint'($signed(d[96:81]));
		w2 = d[108:97];
		h2 = d[120:109];
		a2 = int'(d[129:121]) % 360;
		dx = x1 - x2;
		dy = y1 - y2;
		// Axis-aligned special case with strict comparisons.
		if ((a1 == 90 || a1 == 270) && a2 == 90) begin
			sx = w1 + w2;
			sy = h1 + h2;
			return (2 * dx < sx) && (2 * dx > -sx) && (2 * dy < sy) && (2 * dy > -sy);
		end
		ux[0] = sin_deg(a1 + 90); uy[0] = sin_deg(a1);       len[0] = h1;
		ux[1] = sin_deg(a1);      uy[1] = -sin_deg(a1 + 90); len[1] = w1;
		ux[2] = sin_deg(a2 + 90); uy[2] = sin_deg(a2);       len[2] = h2;
		ux[3] = sin_deg(a2);      uy[3] = -sin_deg(a2 + 90); len[3] = w2;
		// Separating-axis test; touching counts as separated.
		for (int i = 0; i < 4; i++) begin
			if (len[i] == 0) begin
				return 1'b0;
			end
			proj = abs_of(dx * ux[i] + dy * uy[i]);
			sum  = 0;
			for (int j = 0; j < 4; j++) begin
				sum += len[j] * abs_of(ux[j] * ux[i] + uy[j] * uy[i]);
			end
			need = (sum + (longint'(1) << (TRIG_FRAC_BITS + 1)) - 1) >>> (TRIG_FRAC_BITS + 1);
			if (proj >= need) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Record each accepted pair and check each accepted result word.
	always @(posedge clk) begin
		bit expected;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				overlap_q.push_back(predict_overlap(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (overlap_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h", m_tdata));
				end else begin
					expected = overlap_q.pop_front();
					if (m_tdata !== {{(OUT_DATA_W-1){1'b0}}, expected}) begin
						report_mismatch($sformatf("overlap got %h expected %0d",
							m_tdata, expected));
					end
				end
			end
			pending = overlap_q.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Oriented box overlap bench
// Drives rectangle pairs into the block, directed corners first and then
// random pairs, with random gaps and stalls on both sides, and gives the
// verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module tb_top;
	import obb_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// first_center_x, first_center_y, first_width, first_height, first_angle,
	// second_center_x, second_center_y, second_width, second_height,
	// second_angle, zero fill
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	// overlap, zero fill
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    errors;
	int                    pending;
	int                    cycles;

	oriented_box_overlap_test_top i_dut (.*);

	obb_checker i_checker (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Gaps are suppressed in a quiet window of the run.
	function automatic bit take_gap();
		if (cycles >= 3000 && cycles < 4500) begin
			return 1'b0;
		end
		return $urandom_range(99) < 35;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_pair(
		int x1, int y1, int w1, int h1, int a1,
		int x2, int y2, int w2, int h2, int a2);
		logic [IN_DATA_W-1:0] d;
		d = '0;
		d[15:0]    = 16'(x1);
		d[31:16]   = 16'(y1);
		d[43:32]   = 12'(w1);
		d[55:44]   = 12'(h1);
		d[64:56]   = 9'(a1);
		d[80:65]   = 16'(x2);
		d[96:81]   = 16'(y2);
		d[108:97]  = 12'(w2);
		d[120:109] = 12'(h2);
		d[129:121] = 9'(a2);
		return d;
	endfunction

	// Offer one word, with a random gap ahead of it, until it is taken.
	task automatic send_word(logic [IN_DATA_W-1:0] d);
		while (take_gap()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random_pair();
		int x1, y1, x2, y2, w1, h1, w2, h2, a1, a2, span;
		w1 = ($urandom_range(19) == 0) ? 0 : $urandom_range(4095);
		h1 = ($urandom_range(19) == 0) ? 0 : $urandom_range(4095);
		w2 = ($urandom_range(19) == 0) ? 0 : $urandom_range(4095);
		h2 = ($urandom_range(19) == 0) ? 0 : $urandom_range(4095);
		x1 = int'($signed(16'($urandom)));
		y1 = int'($signed(16'($urandom)));
		// Mostly neighbors, so that both verdicts are common.
		span = ($urandom_range(9) == 0) ? 32767 : $urandom_range(4095);
		x2 = x1 + $urandom_range(2 * span) - span;
		y2 = y1 + $urandom_range(2 * span) - span;
		if ($urandom_range(3) == 0) begin
			a1 = $urandom_range(1) ? ($urandom_range(1) ? 90 : 450) : 270;
			a2 = $urandom_range(1) ? 90 : 450;
		end else begin
			a1 = $urandom_range(511);
			a2 = $urandom_range(511);
		end
		send_word(pack_pair(x1, y1, w1, h1, a1, x2, y2, w2, h2, a2));
	endtask

	// Cycle count and overall time limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: an early long hold-off, then random stalls.
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		repeat (40) @(posedge clk);
		repeat (300) @(posedge clk);
		forever begin
			m_tready <= !take_gap();
			@(posedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		arst_n   = 1'b0;
		repeat (4) @(posedge clk);
		arst_n   = 1'b1;
		@(posedge clk);

		// Axis-aligned case: overlap, touching on each axis, zero extents.
		send_word(pack_pair(0, 0, 10, 10, 90, 4, 4, 10, 10, 90));
		send_word(pack_pair(0, 0, 10, 10, 270, 10, 0, 10, 10, 90));
		send_word(pack_pair(0, 0, 10, 10, 90, 0, -10, 10, 10, 90));
		send_word(pack_pair(0, 0, 0, 0, 90, 0, 0, 0, 0, 90));
		send_word(pack_pair(0, 0, 0, 4, 90, 0, 0, 2, 0, 450));
		// Rotated case: touching, overlap, zero width or height.
		send_word(pack_pair(0, 0, 10, 10, 0, 10, 0, 10, 10, 0));
		send_word(pack_pair(0, 0, 10, 10, 45, 3, 3, 10, 10, 30));
		send_word(pack_pair(0, 0, 0, 10, 0, 0, 0, 10, 10, 0));
		send_word(pack_pair(0, 0, 10, 10, 0, 0, 0, 10, 0, 180));
		send_word(pack_pair(0, 0, 10, 10, 90, 0, 0, 10, 10, 270));
		// Angles above 359, coordinate and size extremes.
		send_word(pack_pair(5, 5, 20, 8, 360, 0, 0, 8, 20, 511));
		send_word(pack_pair(5, 5, 20, 8, 450, 0, 0, 8, 20, 359));
		send_word(pack_pair(-32768, -32768, 4095, 4095, 0, 32767, 32767, 4095, 4095, 0));
		send_word(pack_pair(32767, 32767, 4095, 4095, 90, -32768, -32768, 4095, 4095, 90));
		send_word(pack_pair(-32768, 32767, 4095, 4095, 180, -32768, 32767, 4095, 4095, 1));
		send_word(pack_pair(100, -100, 4095, 1, 89, 100, -100, 1, 4095, 91));
		send_word(pack_pair(0, 0, 4095, 4095, 271, 2000, 2000, 4095, 4095, 269));
		send_word(pack_pair(-1, -1, 1, 1, 0, 0, 0, 1, 1, 0));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Midway the sender waits until every result is back.
			if (n == RANDOM_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			send_random_pair();
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (30) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
